FILE: design/pf_pkg.sv
// Shared types, constants and the control program of the prime factorizer.
// No dependencies; compiled first.
package pf_pkg;

    localparam int FACTOR_BITS = 16;                 // width of a result factor
    localparam int LIST_DEPTH  = 16;                 // factors kept for output
    localparam int LIST_BITS   = $clog2(LIST_DEPTH);
    localparam int CNT_BITS    = $clog2(LIST_DEPTH + 1);
    localparam int INPUT_BITS  = 16;                 // width of the input value field

    localparam int PC_BITS     = 4;
    localparam int OP_BITS     = 4;
    localparam int COND_BITS   = 3;

    typedef logic [PC_BITS-1:0]   t_pc;
    typedef logic [OP_BITS-1:0]   t_op;
    typedef logic [COND_BITS-1:0] t_cond;

    // datapath operations
    localparam t_op OP_NOP       = 4'd0;
    localparam t_op OP_LOAD      = 4'd1;   // take the input item when it fires
    localparam t_op OP_SQ        = 4'd2;   // square the trial divisor
    localparam t_op OP_DIV_INIT  = 4'd3;
    localparam t_op OP_DIV_STEP  = 4'd4;   // one quotient bit
    localparam t_op OP_PUSH_D    = 4'd5;   // record divisor, keep quotient
    localparam t_op OP_INC_D     = 4'd6;
    localparam t_op OP_PUSH_N    = 4'd7;   // record leftover if above one
    localparam t_op OP_EMIT      = 4'd8;   // present results, pop on handshake
    localparam t_op OP_PUSH_ZERO = 4'd9;   // the no-factor result

    // jump conditions
    localparam t_cond C_NONE      = 3'd0;
    localparam t_cond C_ALWAYS    = 3'd1;
    localparam t_cond C_NO_IN     = 3'd2;
    localparam t_cond C_N_LT2     = 3'd3;
    localparam t_cond C_SQ_GT_N   = 3'd4;
    localparam t_cond C_DIV_MORE  = 3'd5;
    localparam t_cond C_REM_NZ    = 3'd6;
    localparam t_cond C_EMIT_MORE = 3'd7;

    // program steps
    localparam t_pc S_IDLE     = 4'd0;
    localparam t_pc S_SMALL    = 4'd1;
    localparam t_pc S_SQUARE   = 4'd2;
    localparam t_pc S_TEST     = 4'd3;
    localparam t_pc S_DIV_INIT = 4'd4;
    localparam t_pc S_DIV_STEP = 4'd5;
    localparam t_pc S_CHK_REM  = 4'd6;
    localparam t_pc S_PUSH_D   = 4'd7;
    localparam t_pc S_NEXT_D   = 4'd8;
    localparam t_pc S_TAIL     = 4'd9;
    localparam t_pc S_EMIT     = 4'd10;
    localparam t_pc S_DONE     = 4'd11;
    localparam t_pc S_ZERO     = 4'd12;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // control store
    function automatic t_uword pf_program(input t_pc pc);
        t_uword w;
        unique case (pc)
            S_IDLE:     w = '{OP_LOAD,      C_NO_IN,     S_IDLE};
            S_SMALL:    w = '{OP_NOP,       C_N_LT2,     S_ZERO};
            S_SQUARE:   w = '{OP_SQ,        C_NONE,      S_IDLE};
            S_TEST:     w = '{OP_NOP,       C_SQ_GT_N,   S_TAIL};
            S_DIV_INIT: w = '{OP_DIV_INIT,  C_NONE,      S_IDLE};
            S_DIV_STEP: w = '{OP_DIV_STEP,  C_DIV_MORE,  S_DIV_STEP};
            S_CHK_REM:  w = '{OP_NOP,       C_REM_NZ,    S_NEXT_D};
            S_PUSH_D:   w = '{OP_PUSH_D,    C_ALWAYS,    S_DIV_INIT};
            S_NEXT_D:   w = '{OP_INC_D,     C_ALWAYS,    S_SQUARE};
            S_TAIL:     w = '{OP_PUSH_N,    C_NONE,      S_IDLE};
            S_EMIT:     w = '{OP_EMIT,      C_EMIT_MORE, S_EMIT};
            S_DONE:     w = '{OP_NOP,       C_ALWAYS,    S_IDLE};
            S_ZERO:     w = '{OP_PUSH_ZERO, C_ALWAYS,    S_EMIT};
            default:    w = '{OP_NOP,       C_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: design/pf_value_if.sv
// Input channel of the prime factorizer: valid/ready plus the value to factor.
// Depends on pf_pkg.
interface pf_value_if import pf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [INPUT_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: design/pf_factor_if.sv
// Result channel of the prime factorizer: valid/ready plus one factor and last flag.
// Depends on pf_pkg.
interface pf_factor_if import pf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FACTOR_BITS-1:0] factor;
    logic                   last;

    modport source (output valid, output factor, output last, input ready);
    modport sink   (input valid, input factor, input last, output ready);
endinterface

FILE: design/prime_factorizer_top.sv
// Prime factorizer: microcoded trial-division sequencer with a bit-serial divider.
// Depends on pf_pkg, pf_value_if, pf_factor_if.
//
// Usage
//   i_in  carries one unsigned value per item; only its low VALUE_BITS bits count.
//   o_out returns the prime factors of that value with multiplicity, largest
//   first, one per item, with last set on the final one. Values 0 and 1 give
//   one item with factor 0 and last set. Only the 16 largest factors are kept;
//   a factor wider than 16 bits is returned as its low 16 bits.
// Timing
//   One value is worked on at a time; i_in.ready is high only while idle.
//   Each trial divisor runs square, compare, divider init, VALUE_BITS divide
//   steps, remainder check and increment; each factor found runs a push, the
//   divider init, the divide steps and the remainder check again. The divider,
//   one quotient bit per cycle, sets the pace. Results then go out one per
//   cycle while the receiver is ready, followed by a done step back to idle.
// Reset and stalls
//   Synchronous active-low reset returns the step counter to idle; any item in
//   progress is dropped. A stalled receiver simply holds the emit step, the
//   presented factor stays put until taken.
module prime_factorizer_top import pf_pkg::*; #(
    parameter int VALUE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pf_value_if.sink     i_in,
    pf_factor_if.source  o_out
);

    localparam int D_BITS    = (VALUE_BITS + 1) / 2 + 1;   // trial divisor never passes 2^ceil(VB/2)
    localparam int SQ_BITS   = 2 * D_BITS;
    localparam int BCNT_BITS = $clog2(VALUE_BITS);

    // sequencer
    t_pc    r_pc, n_pc;
    t_uword uw;
    logic   cond_true;

    // datapath
    logic [VALUE_BITS-1:0]  r_n, n_n;          // value still to factor
    logic [D_BITS-1:0]      r_d, n_d;          // trial divisor
    logic [SQ_BITS-1:0]     r_sq, n_sq;
    logic [D_BITS-1:0]      r_rem, n_rem;      // divider remainder
    logic [VALUE_BITS-1:0]  r_quo, n_quo;      // dividend shifting out, quotient in
    logic [BCNT_BITS-1:0]   r_bcnt, n_bcnt;
    logic [LIST_BITS-1:0]   r_wp, n_wp;        // next free slot in the factor ring
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;      // factors held, saturates at depth
    logic [FACTOR_BITS-1:0] r_list [LIST_DEPTH];

    logic                   list_we;
    logic [FACTOR_BITS-1:0] list_wdata;
    logic [LIST_BITS-1:0]   rd_ptr;

    logic                   in_fire, out_fire;
    logic [D_BITS:0]        div_shift, div_diff;
    logic                   div_ge;

    assign uw       = pf_program(r_pc);
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    // restoring divide step
    assign div_shift = {r_rem, r_quo[VALUE_BITS-1]};
    assign div_diff  = div_shift - {1'b0, r_d};
    assign div_ge    = (div_shift >= {1'b0, r_d});

    // ports
    assign i_in.ready   = (r_pc == S_IDLE);
    assign rd_ptr       = r_wp - LIST_BITS'(1);
    assign o_out.valid  = (uw.op == OP_EMIT);
    assign o_out.factor = r_list[rd_ptr];
    assign o_out.last   = (r_cnt == CNT_BITS'(1));

    // jump condition
    always_comb begin
        unique case (uw.cond)
            C_NONE:      cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_IN:     cond_true = !in_fire;
            C_N_LT2:     cond_true = (r_n < VALUE_BITS'(2));
            C_SQ_GT_N:   cond_true = (r_sq > {{(SQ_BITS-VALUE_BITS){1'b0}}, r_n});
            C_DIV_MORE:  cond_true = (r_bcnt != '0);
            C_REM_NZ:    cond_true = (r_rem != '0);
            C_EMIT_MORE: cond_true = !(out_fire && o_out.last);
            default:     cond_true = 1'b0;
        endcase
        n_pc = cond_true ? uw.target : r_pc + PC_BITS'(1);
    end

    // datapath operation decode
    always_comb begin
        n_n        = r_n;
        n_d        = r_d;
        n_sq       = r_sq;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_bcnt     = r_bcnt;
        n_wp       = r_wp;
        n_cnt      = r_cnt;
        list_we    = 1'b0;
        list_wdata = 16'(r_d);
        unique case (uw.op)
            OP_NOP: begin
            end
            OP_LOAD: begin
                if (in_fire) begin
                    n_n   = VALUE_BITS'(i_in.value);
                    n_d   = D_BITS'(2);
                    n_wp  = '0;
                    n_cnt = '0;
                end
            end
            OP_SQ: begin
                n_sq = r_d * r_d;
            end
            OP_DIV_INIT: begin
                n_rem  = '0;
                n_quo  = r_n;
                n_bcnt = BCNT_BITS'(VALUE_BITS - 1);
            end
            OP_DIV_STEP: begin
                n_rem  = div_ge ? div_diff[D_BITS-1:0] : div_shift[D_BITS-1:0];
                n_quo  = {r_quo[VALUE_BITS-2:0], div_ge};
                n_bcnt = r_bcnt - BCNT_BITS'(1);
            end
            OP_PUSH_D: begin
                list_we = 1'b1;
                n_n     = r_quo;
            end
            OP_INC_D: begin
                n_d = r_d + D_BITS'(1);
            end
            OP_PUSH_N: begin
                list_wdata = 16'(r_n);
                list_we    = (r_n > VALUE_BITS'(1));
            end
            OP_EMIT: begin
                if (out_fire) begin
                    n_wp  = rd_ptr;
                    n_cnt = r_cnt - CNT_BITS'(1);
                end
            end
            OP_PUSH_ZERO: begin
                list_wdata = '0;
                list_we    = 1'b1;
            end
            default: begin
            end
        endcase
        // ring keeps the newest entries; count saturates at the ring depth
        if (list_we) begin
            n_wp = r_wp + LIST_BITS'(1);
            if (r_cnt != CNT_BITS'(LIST_DEPTH)) begin
                n_cnt = r_cnt + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_d    <= n_d;
        r_sq   <= n_sq;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_bcnt <= n_bcnt;
        r_wp   <= n_wp;
        r_cnt  <= n_cnt;
        if (list_we) begin
            r_list[r_wp] <= list_wdata;
        end
    end

endmodule

FILE: design/pf_checker.sv
// Port-level checks for the prime factorizer, bound to prime_factorizer_top.
// Depends on pf_pkg and the top level's channel interfaces.
module pf_checker import pf_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [FACTOR_BITS-1:0] i_out_factor,
    input logic                   i_out_last
);

    // never takes a new value while results are on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_out_valid && i_in_ready))
        else $error("input ready while result is valid");

    // a taken value closes the input until its results are out
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    // the final result ends the burst
    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> !i_out_valid)
        else $error("result valid right after the last one was taken");

    // the no-factor marker always stands alone
    a_zero_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_factor == '0)) |-> i_out_last)
        else $error("factor zero without last");

endmodule

bind prime_factorizer_top pf_checker u_pf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_factor (o_out.factor),
    .i_out_last   (o_out.last)
);

FILE: verif/pf_factor_checker.sv
// Scoreboard for the prime factorizer: watches both channels, predicts the factor list.
// Depends on pf_pkg, pf_value_if, pf_factor_if.
module pf_factor_checker import pf_pkg::*; #(
    parameter int VALUE_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pf_value_if  i_in_mon,
    pf_factor_if i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_values_seen,
    output int   o_factors_seen
);

    typedef struct packed {
        logic [FACTOR_BITS-1:0] factor;
        logic                   last;
    } t_factor_item;

    t_factor_item factors_due[$];
    int           fails        = 0;
    int           values_seen  = 0;
    int           factors_seen = 0;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_values_seen  = 0;
        o_factors_seen = 0;
    end

    // trial division, then the list goes out largest first, capped at LIST_DEPTH
    function automatic void queue_prime_factors(input logic [INPUT_BITS-1:0] raw);
        longint unsigned n;
        longint unsigned d;
        longint unsigned ascending[$];
        int              emit;
        t_factor_item    item;
        n = longint'(raw) & ((64'd1 << VALUE_BITS) - 64'd1);
        if (n < 2) begin
            item.factor = '0;
            item.last   = 1'b1;
            factors_due.push_back(item);
            return;
        end
        d = 2;
        while (d * d <= n) begin
            while (n % d == 0) begin
                ascending.push_back(d);
                n = n / d;
            end
            d++;
        end
        if (n > 1)
            ascending.push_back(n);
        emit = (ascending.size() < LIST_DEPTH) ? ascending.size() : LIST_DEPTH;
        for (int k = 0; k < emit; k++) begin
            item.factor = ascending[ascending.size() - 1 - k][FACTOR_BITS-1:0];
            item.last   = (k == emit - 1);
            factors_due.push_back(item);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_factor_item want;
        if (!i_rst_n) begin
            factors_due.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                queue_prime_factors(i_in_mon.value);
                values_seen++;
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                factors_seen++;
                if (factors_due.size() == 0) begin
                    if (fails < 10)
                        $display("[%0t] unexpected result: factor %0d last %0b",
                                 $realtime, i_out_mon.factor, i_out_mon.last);
                    fails++;
                end else begin
                    want = factors_due.pop_front();
                    if (i_out_mon.factor !== want.factor || i_out_mon.last !== want.last) begin
                        if (fails < 10)
                            $display("[%0t] mismatch: factor exp %0d got %0d, last exp %0b got %0b",
                                     $realtime, want.factor, i_out_mon.factor,
                                     want.last, i_out_mon.last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count   <= fails;
        o_pending      <= factors_due.size();
        o_values_seen  <= values_seen;
        o_factors_seen <= factors_seen;
    end

endmodule

FILE: verif/prime_factorizer_top_tb.sv
// Testbench top for prime_factorizer_top: clock, reset, value stimulus and verdict.
// Depends on pf_pkg, pf_value_if, pf_factor_if, pf_factor_checker and the block itself.
module prime_factorizer_top_tb import pf_pkg::*; ();

    localparam int VALUE_BITS    = 16;
    localparam int PHASE_ITEMS   = 30;     // random values per pacing phase
    localparam int DRAIN_CYCLES  = 32;     // block passes a done step back to idle after the last result
    // Set well above the slowest clean run: 142 values, each costing as much as a
    // 16-bit prime, plus 16 stalled results each.
    localparam int CYCLE_LIMIT   = 4_000_000;

    logic i_clk;
    logic i_rst_n;

    pf_value_if  in_if ();
    pf_factor_if out_if ();

    int fail_count;
    int pending;
    int values_seen;
    int factors_seen;

    int          idle_pct  = 0;    // sender: chance to hold valid low per cycle
    int          stall_pct = 0;    // receiver: chance to hold ready low per cycle
    int unsigned cycles    = 0;

    prime_factorizer_top #(
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    pf_factor_checker #(
        .VALUE_BITS (VALUE_BITS)
    ) u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_mon       (in_if),
        .i_out_mon      (out_if),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_values_seen  (values_seen),
        .o_factors_seen (factors_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random backpressure, rate set per phase.
    initial out_if.ready = 1'b0;
    always @(posedge i_clk)
        out_if.ready <= ($urandom_range(99) >= stall_pct);

    // Hard stop if the block hangs; cycles also feeds the summary.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offer one value and return at the edge where it is taken.
    // Entered at a rising edge. When no gap is drawn valid just stays high,
    // so it never gets a low and a high in the same step.
    // ready is looked at on the falling edge: it only moves on rising edges,
    // so that read is what the next rising edge will see.
    task automatic push_value(input logic [INPUT_BITS-1:0] v);
        if ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        do @(negedge i_clk); while (!in_if.ready);
        @(posedge i_clk);
    endtask

    // Mix of value shapes. Full-range values reach every input bit but can be
    // slow (a prime is the slowest case), so they are only a share:
    //  - full 16-bit range
    //  - small values, cheap, many tiny factor lists
    //  - smooth numbers: long lists of repeated small primes, deep in the list
    //  - products of two numbers just under 256: divisor loop runs near sqrt,
    //    leftover pushed as the tail factor
    function automatic logic [INPUT_BITS-1:0] draw_value();
        int pick;
        int v;
        int p;
        pick = $urandom_range(99);
        if (pick < 35) begin
            v = $urandom_range(65535);
        end else if (pick < 60) begin
            v = $urandom_range(1023);
        end else if (pick < 85) begin
            v = 1;
            repeat ($urandom_range(16, 1)) begin
                case ($urandom_range(5))
                    0:       p = 2;
                    1:       p = 3;
                    2:       p = 5;
                    3:       p = 7;
                    4:       p = 11;
                    default: p = 13;
                endcase
                if (v * p <= 65535)
                    v = v * p;
            end
        end else begin
            v = $urandom_range(255, 200) * $urandom_range(255, 200);
        end
        return v[INPUT_BITS-1:0];
    endfunction

    task automatic run_phase(input int sender_idle, input int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct <= receiver_stall;
        repeat (PHASE_ITEMS)
            push_value(draw_value());
    endtask

    initial begin
        logic [INPUT_BITS-1:0] directed [$];

        in_if.valid = 1'b0;
        in_if.value = '0;
        i_rst_n     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: the no-factor inputs (zero, one), small primes and squares,
        // the longest list (2^15), high powers, squares of primes right at the
        // d*d <= n boundary, a product of two large primes, the largest 16-bit
        // prime and the all-ones value.
        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd9, 16'd25,
                     16'd30030, 16'd32767, 16'd32768, 16'd49152, 16'd59049,
                     16'd15625, 16'd16807, 16'd46189, 16'd63001, 16'd64507,
                     16'd65025, 16'd65521, 16'd65534, 16'd65535};
        foreach (directed[i])
            push_value(directed[i]);

        // Pacing phases: free flow, slow sender, slow receiver, both.
        run_phase(0, 0);
        run_phase(70, 0);
        run_phase(0, 70);
        run_phase(31, 31);
        in_if.valid <= 1'b0;

        // pending is updated with nonblocking writes, so read it mid-cycle
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        $display("Run covered %0d values and %0d factor results over four pacing phases",
                 values_seen, factors_seen);
        $display("in %0d cycles; %0d failures", cycles, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
